>>> rtl/fsgd_pkg.sv
// shared constants and types of the factorization sgd rating step
package fsgd_pkg;

    // fixed field widths
    localparam int DATA_WIDTH      = 32;
    localparam int INDEX_WIDTH     = 14;
    localparam int REMAIN_WIDTH    = 8;
    localparam int SQ_WIDTH        = 63;
    localparam int CFG_INDEX_WIDTH = 3;

    // parameter defaults
    localparam int NUM_USERS_DEFAULT   = 16384;
    localparam int NUM_ITEMS_DEFAULT   = 16384;
    localparam int VALUE_WIDTH_DEFAULT = 32;

    // reset value of the ceiling, 10.0 in q16.16
    localparam logic signed [DATA_WIDTH-1:0] CEILING_RESET = 32'sd655360;

    // request commands
    typedef enum logic [1:0] {
        CMD_TRAIN      = 2'd0,
        CMD_CACHE      = 2'd1,
        CMD_WRITE_USER = 2'd2,
        CMD_WRITE_ITEM = 2'd3
    } cmd_t;

    // register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_STEP_RATE      = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_REGULARIZATION = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INITIAL        = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_REMAINING      = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FLOOR          = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CEILING        = 3'd5;

endpackage

>>> rtl/factorization_sgd_rating_step.sv
// top level: feature tables in two memories and a sequencer around one shared 32x32 multiplier
//
//  channel   ports                         handshake
//  request   s_command .. s_write_value    s_valid / s_ready
//  result    m_prediction .. m_new_item_*  m_valid / m_ready
//  config    cfg_index, cfg_data           cfg_wr_en, no wait
//
// train runs through every datapath state, cache stops after the prediction, a table write
// after the address state; a table smaller than the index range adds the index wrap states.
// the sequence is set by the single 32x32 multiplier, used nine times in train.
// reset is synchronous and clears control and configuration, not the tables.
// a request is taken only in idle; a waiting result holds the sequencer in its last state.
module factorization_sgd_rating_step
    import fsgd_pkg::*;
#(
    parameter int NUM_USERS   = NUM_USERS_DEFAULT,
    parameter int NUM_ITEMS   = NUM_ITEMS_DEFAULT,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0]        cfg_index,
    input  logic [DATA_WIDTH-1:0]             cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_command,
    input  logic [INDEX_WIDTH-1:0]            s_user_index,
    input  logic [INDEX_WIDTH-1:0]            s_item_index,
    input  logic signed [DATA_WIDTH-1:0]      s_rating,
    input  logic signed [DATA_WIDTH-1:0]      s_prior_sum,
    input  logic signed [DATA_WIDTH-1:0]      s_baseline,
    input  logic signed [DATA_WIDTH-1:0]      s_write_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [DATA_WIDTH-1:0]      m_prediction,
    output logic signed [DATA_WIDTH-1:0]      m_error,
    output logic [SQ_WIDTH-1:0]               m_squared_error,
    output logic signed [DATA_WIDTH-1:0]      m_new_user_feature,
    output logic signed [DATA_WIDTH-1:0]      m_new_item_feature
);

    localparam int UA_W = $clog2(NUM_USERS);
    localparam int IA_W = $clog2(NUM_ITEMS);
    localparam bit NEED_WRAP = (NUM_USERS < (1 << INDEX_WIDTH)) ||
                               (NUM_ITEMS < (1 << INDEX_WIDTH));
    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    typedef enum logic [3:0] {
        S_IDLE, S_RED0, S_RED1, S_ADDR, S_FEAT, S_PRED, S_ERR,
        S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_OUT
    } state_t;

    // round q32.32 to q16.16, ties toward plus infinity
    function automatic logic signed [63:0] rnd_q(input logic signed [63:0] x);
        logic signed [64:0] t;
        t = {x[63], x} + 65'sd32768;
        return 64'(t >>> 16);
    endfunction

    function automatic logic signed [63:0] sat_v(input logic signed [63:0] v);
        if (v > SAT_HI) return SAT_HI;
        if (v < SAT_LO) return SAT_LO;
        return v;
    endfunction

    // seven compare and subtract steps of the index wrap, from bit hi_k down
    function automatic logic [INDEX_WIDTH-1:0] reduce_part(
        input logic [INDEX_WIDTH-1:0] r, input int n, input int hi_k);
        logic [INDEX_WIDTH-1:0] v;
        logic [63:0] m;
        v = r;
        for (int k = 0; k < 7; k++) begin
            m = 64'(n) << (hi_k - k);
            if (64'(v) >= m) v = v - m[INDEX_WIDTH-1:0];
        end
        return v;
    endfunction

    // configuration
    logic signed [DATA_WIDTH-1:0] step_rate_reg, regularization_reg, initial_reg;
    logic signed [DATA_WIDTH-1:0] floor_reg, ceiling_reg;
    logic [REMAIN_WIDTH-1:0]      remaining_reg;

    // request and working registers
    state_t                       state_reg;
    cmd_t                         cmd_reg;
    logic [INDEX_WIDTH-1:0]       uidx_reg, iidx_reg;
    logic signed [DATA_WIDTH-1:0] rating_reg, prior_reg, baseline_reg, wval_in_reg;
    logic signed [DATA_WIDTH-1:0] u_reg, it_reg;
    logic signed [63:0]           mul_reg, trail_reg, pred_reg, err_reg, ru_reg, rit_reg;
    logic signed [63:0]           du_reg, di_reg, nu_reg, ni_reg;
    logic [SQ_WIDTH-1:0]          sq_reg;

    // result register
    logic                         m_valid_reg;
    logic signed [DATA_WIDTH-1:0] out_pred_reg, out_err_reg, out_nu_reg, out_ni_reg;
    logic [SQ_WIDTH-1:0]          out_sq_reg;

    // memories
    logic [VALUE_WIDTH-1:0]        user_mem [NUM_USERS];
    logic [VALUE_WIDTH-1:0]        item_mem [NUM_ITEMS];
    logic signed [VALUE_WIDTH-1:0] u_rd_reg, it_rd_reg;
    logic                          user_we, item_we;
    logic [UA_W-1:0]               user_addr;
    logic [IA_W-1:0]               item_addr;
    logic [VALUE_WIDTH-1:0]        user_wdata, item_wdata;

    // combinational helpers
    logic signed [DATA_WIDTH-1:0] mul_a, mul_b;
    logic signed [63:0]           wval, base, pred1, sum2, pred2, mul_rnd;
    logic                         out_free, accept;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign m_valid            = m_valid_reg;
    assign m_prediction       = out_pred_reg;
    assign m_error            = out_err_reg;
    assign m_squared_error    = out_sq_reg;
    assign m_new_user_feature = out_nu_reg;
    assign m_new_item_feature = out_ni_reg;

    // prediction arithmetic
    always_comb begin
        wval    = sat_v(64'(wval_in_reg));
        base    = (prior_reg > 0) ? 64'(prior_reg) : 64'(baseline_reg);
        mul_rnd = rnd_q(mul_reg);
        pred1   = sat_v(base + mul_rnd);
        if (pred1 > 64'(ceiling_reg)) begin
            pred1 = 64'(ceiling_reg);
        end else if (pred1 < 64'(floor_reg)) begin
            pred1 = 64'(floor_reg);
        end
        sum2  = sat_v(pred_reg + trail_reg);
        pred2 = sum2;
        if (sum2 > 64'(ceiling_reg)) begin
            pred2 = 64'(ceiling_reg);
        end else if (sum2 < 64'(floor_reg)) begin
            pred2 = 64'(floor_reg);
        end
    end

    // shared multiplier operands
    always_comb begin
        unique case (state_reg)
            S_ADDR: begin
                mul_a = initial_reg;        mul_b = initial_reg;
            end
            S_FEAT: begin
                mul_a = 32'(it_rd_reg);     mul_b = 32'(u_rd_reg);
            end
            S_PRED: begin
                mul_a = regularization_reg; mul_b = u_reg;
            end
            S_ERR: begin
                mul_a = regularization_reg; mul_b = it_reg;
            end
            S_M1: begin
                mul_a = err_reg[31:0];      mul_b = it_reg;
            end
            S_M2: begin
                mul_a = err_reg[31:0];      mul_b = u_reg;
            end
            S_M3: begin
                mul_a = step_rate_reg;      mul_b = du_reg[31:0];
            end
            S_M4: begin
                mul_a = step_rate_reg;      mul_b = di_reg[31:0];
            end
            S_M5: begin
                mul_a = err_reg[31:0];      mul_b = err_reg[31:0];
            end
            default: begin
                mul_a = '0;                 mul_b = '0;
            end
        endcase
    end

    // memory port control
    always_comb begin
        user_addr  = UA_W'(uidx_reg);
        item_addr  = IA_W'(iidx_reg);
        user_we    = 1'b0;
        item_we    = 1'b0;
        user_wdata = nu_reg[VALUE_WIDTH-1:0];
        item_wdata = ni_reg[VALUE_WIDTH-1:0];
        if (state_reg == S_ADDR) begin
            user_we    = (cmd_reg == CMD_WRITE_USER);
            item_we    = (cmd_reg == CMD_WRITE_ITEM);
            user_wdata = wval[VALUE_WIDTH-1:0];
            item_wdata = wval[VALUE_WIDTH-1:0];
        end else if (state_reg == S_OUT && out_free && cmd_reg == CMD_TRAIN) begin
            user_we = 1'b1;
            item_we = 1'b1;
        end
    end

    // feature tables
    always_ff @(posedge aclk) begin
        if (user_we) begin
            user_mem[user_addr] <= user_wdata;
        end
        u_rd_reg <= user_mem[user_addr];
    end

    always_ff @(posedge aclk) begin
        if (item_we) begin
            item_mem[item_addr] <= item_wdata;
        end
        it_rd_reg <= item_mem[item_addr];
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_rate_reg      <= '0;
            regularization_reg <= '0;
            initial_reg        <= '0;
            remaining_reg      <= '0;
            floor_reg          <= '0;
            ceiling_reg        <= CEILING_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_STEP_RATE:      step_rate_reg      <= cfg_data;
                REG_REGULARIZATION: regularization_reg <= cfg_data;
                REG_INITIAL:        initial_reg        <= cfg_data;
                REG_REMAINING:      remaining_reg      <= cfg_data[REMAIN_WIDTH-1:0];
                REG_FLOOR:          floor_reg          <= cfg_data;
                REG_CEILING:        ceiling_reg        <= cfg_data;
                default:            ;
            endcase
        end
    end

    // sequencer and datapath
    always_ff @(posedge aclk) begin
        mul_reg <= mul_a * mul_b;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !(state_reg == S_OUT && out_free)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        cmd_reg      <= cmd_t'(s_command);
                        uidx_reg     <= s_user_index;
                        iidx_reg     <= s_item_index;
                        rating_reg   <= s_rating;
                        prior_reg    <= s_prior_sum;
                        baseline_reg <= s_baseline;
                        wval_in_reg  <= s_write_value;
                        state_reg    <= NEED_WRAP ? S_RED0 : S_ADDR;
                    end
                end
                S_RED0: begin
                    uidx_reg  <= reduce_part(uidx_reg, NUM_USERS, INDEX_WIDTH - 1);
                    iidx_reg  <= reduce_part(iidx_reg, NUM_ITEMS, INDEX_WIDTH - 1);
                    state_reg <= S_RED1;
                end
                S_RED1: begin
                    uidx_reg  <= reduce_part(uidx_reg, NUM_USERS, INDEX_WIDTH - 8);
                    iidx_reg  <= reduce_part(iidx_reg, NUM_ITEMS, INDEX_WIDTH - 8);
                    state_reg <= S_ADDR;
                end
                S_ADDR: begin
                    // table writes finish here, reads are issued otherwise
                    pred_reg <= '0;
                    err_reg  <= '0;
                    sq_reg   <= '0;
                    nu_reg   <= (cmd_reg == CMD_WRITE_USER) ? wval : 64'sd0;
                    ni_reg   <= (cmd_reg == CMD_WRITE_ITEM) ? wval : 64'sd0;
                    if (cmd_reg == CMD_WRITE_USER || cmd_reg == CMD_WRITE_ITEM) begin
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_FEAT;
                    end
                end
                S_FEAT: begin
                    u_reg     <= 32'(u_rd_reg);
                    it_reg    <= 32'(it_rd_reg);
                    trail_reg <= $signed({1'b0, remaining_reg}) * mul_rnd;
                    state_reg <= S_PRED;
                end
                S_PRED: begin
                    pred_reg <= pred1;
                    nu_reg   <= 64'(u_reg);
                    ni_reg   <= 64'(it_reg);
                    if (cmd_reg == CMD_CACHE) begin
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_ERR;
                    end
                end
                S_ERR: begin
                    pred_reg  <= pred2;
                    err_reg   <= sat_v(64'(rating_reg) - pred2);
                    ru_reg    <= mul_rnd;
                    state_reg <= S_M1;
                end
                S_M1: begin
                    rit_reg   <= mul_rnd;
                    state_reg <= S_M2;
                end
                S_M2: begin
                    du_reg    <= sat_v(mul_rnd - ru_reg);
                    state_reg <= S_M3;
                end
                S_M3: begin
                    di_reg    <= sat_v(mul_rnd - rit_reg);
                    state_reg <= S_M4;
                end
                S_M4: begin
                    nu_reg    <= sat_v(64'(u_reg) + mul_rnd);
                    state_reg <= S_M5;
                end
                S_M5: begin
                    ni_reg    <= sat_v(64'(it_reg) + mul_rnd);
                    state_reg <= S_M6;
                end
                S_M6: begin
                    sq_reg    <= mul_reg[SQ_WIDTH-1:0];
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    // hand over the result once the output register is free
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        out_pred_reg <= pred_reg[DATA_WIDTH-1:0];
                        out_err_reg  <= err_reg[DATA_WIDTH-1:0];
                        out_sq_reg   <= sq_reg;
                        out_nu_reg   <= nu_reg[DATA_WIDTH-1:0];
                        out_ni_reg   <= ni_reg[DATA_WIDTH-1:0];
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // an accepted request always leaves idle
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg != S_IDLE)
        else $error("request accepted but sequencer stayed idle");

    // a new result appears only from the final state
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the final state");

    // non-train results carry no error
    a_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && cmd_reg != CMD_TRAIN) |-> (err_reg == 0 && sq_reg == 0))
        else $error("error set on a non-train request");

    // tables are written only at load or write-back
    a_write_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (user_we || item_we) |-> (state_reg == S_ADDR || state_reg == S_OUT))
        else $error("table write outside its window");
`endif

endmodule

>>> test/fsgd_step_checker.sv
// checker of the factorization sgd rating step: request predictor and result comparison
module fsgd_step_checker
    import fsgd_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [DATA_WIDTH-1:0]        cfg_data,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [1:0]                   s_command,
    input  logic [INDEX_WIDTH-1:0]       s_user_index,
    input  logic [INDEX_WIDTH-1:0]       s_item_index,
    input  logic signed [DATA_WIDTH-1:0] s_rating,
    input  logic signed [DATA_WIDTH-1:0] s_prior_sum,
    input  logic signed [DATA_WIDTH-1:0] s_baseline,
    input  logic signed [DATA_WIDTH-1:0] s_write_value,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic signed [DATA_WIDTH-1:0] m_prediction,
    input  logic signed [DATA_WIDTH-1:0] m_error,
    input  logic [SQ_WIDTH-1:0]          m_squared_error,
    input  logic signed [DATA_WIDTH-1:0] m_new_user_feature,
    input  logic signed [DATA_WIDTH-1:0] m_new_item_feature,
    output int                           fail_count,
    output int                           pending,
    output int                           results_seen
);

    localparam int TABLE_DEPTH = 1 << INDEX_WIDTH;

    typedef struct {
        logic signed [DATA_WIDTH-1:0] prediction;
        logic signed [DATA_WIDTH-1:0] error;
        logic [SQ_WIDTH-1:0]          squared_error;
        logic signed [DATA_WIDTH-1:0] new_user;
        logic signed [DATA_WIDTH-1:0] new_item;
    } step_result_t;

    step_result_t                 expected_results[$];
    logic signed [DATA_WIDTH-1:0] user_model[TABLE_DEPTH];
    logic signed [DATA_WIDTH-1:0] item_model[TABLE_DEPTH];

    longint step_rate_q, reg_q, initial_q, remaining_q, floor_q, ceiling_q;

    initial begin
        fail_count   = 0;
        pending      = 0;
        results_seen = 0;
    end

    // q32.32 to q16.16, nearest, ties upwards
    function automatic longint round_q16(longint x);
        longint t;
        t = x + 64'sd32768;
        if (t >= 0) return t >>> 16;
        return -(((-t) + 64'sd65535) >>> 16);
    endfunction

    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clip_to_range(longint v);
        if (v > ceiling_q) return ceiling_q;
        if (v < floor_q) return floor_q;
        return v;
    endfunction

    // one request through the feature tables; writes and train requests update the model tables
    function automatic step_result_t predict_step(cmd_t cmd, int ui, int ii,
                                                  longint rating, longint prior,
                                                  longint base_in, longint wval);
        step_result_t r;
        longint u, it, base, pred, err, trail, du, di, nu, ni;
        pred = 0; err = 0; nu = 0; ni = 0;
        if (cmd == CMD_WRITE_USER) begin
            user_model[ui] = 32'(wval);
            nu = wval;
        end else if (cmd == CMD_WRITE_ITEM) begin
            item_model[ii] = 32'(wval);
            ni = wval;
        end else begin
            u    = 64'(user_model[ui]);
            it   = 64'(item_model[ii]);
            base = (prior > 0) ? prior : base_in;
            pred = clip_to_range(sat_word(base + round_q16(it * u)));
            nu   = u;
            ni   = it;
            if (cmd == CMD_TRAIN) begin
                trail = remaining_q * round_q16(initial_q * initial_q);
                pred  = clip_to_range(sat_word(pred + trail));
                err   = sat_word(rating - pred);
                du    = sat_word(round_q16(err * it) - round_q16(reg_q * u));
                di    = sat_word(round_q16(err * u) - round_q16(reg_q * it));
                nu    = sat_word(u + round_q16(step_rate_q * du));
                ni    = sat_word(it + round_q16(step_rate_q * di));
                user_model[ui] = 32'(nu);
                item_model[ii] = 32'(ni);
            end
        end
        r.prediction    = 32'(pred);
        r.error         = 32'(err);
        r.squared_error = 63'(err * err);
        r.new_user      = 32'(nu);
        r.new_item      = 32'(ni);
        return r;
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("mismatch at result %0d: %s got %0h expected %0h",
                 results_seen, field, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        step_result_t want;
        if (!aresetn) begin
            step_rate_q = 0;
            reg_q       = 0;
            initial_q   = 0;
            remaining_q = 0;
            floor_q     = 0;
            ceiling_q   = 64'(CEILING_RESET);
        end else begin
            // register writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_STEP_RATE:      step_rate_q = 64'($signed(cfg_data));
                    REG_REGULARIZATION: reg_q       = 64'($signed(cfg_data));
                    REG_INITIAL:        initial_q   = 64'($signed(cfg_data));
                    REG_REMAINING:      remaining_q = 64'(cfg_data[REMAIN_WIDTH-1:0]);
                    REG_FLOOR:          floor_q     = 64'($signed(cfg_data));
                    REG_CEILING:        ceiling_q   = 64'($signed(cfg_data));
                    default: ;
                endcase
            end
            // accepted request
            if (s_valid && s_ready) begin
                want = predict_step(cmd_t'(s_command),
                    int'(s_user_index), int'(s_item_index), longint'(s_rating),
                    longint'(s_prior_sum), longint'(s_baseline), longint'(s_write_value));
                expected_results = {expected_results, want};
            end
            // accepted result
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("unexpected result %0d with no request waiting", results_seen);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_prediction !== want.prediction)
                        report("prediction", m_prediction, want.prediction);
                    if (m_error !== want.error)
                        report("error", m_error, want.error);
                    if (m_squared_error !== want.squared_error)
                        report("squared_error", m_squared_error, want.squared_error);
                    if (m_new_user_feature !== want.new_user)
                        report("new_user_feature", m_new_user_feature, want.new_user);
                    if (m_new_item_feature !== want.new_item)
                        report("new_item_feature", m_new_item_feature, want.new_item);
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

>>> test/factorization_sgd_rating_step_tb.sv
// testbench top of the factorization sgd rating step: stimulus, idling and verdict
module factorization_sgd_rating_step_tb;
    import fsgd_pkg::*;

    localparam int ITEMS_PER_PHASE = 275;
    localparam int NUM_PHASES      = 6;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int SETTLE_CYCLES   = 30;
    localparam int TABLE_DEPTH     = 1 << INDEX_WIDTH;

    logic                         aclk          = 1'b0;
    logic                         aresetn       = 1'b0;
    logic                         cfg_wr_en     = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0]   cfg_index     = '0;
    logic [DATA_WIDTH-1:0]        cfg_data      = '0;
    logic                         s_valid       = 1'b0;
    logic                         s_ready;
    logic [1:0]                   s_command     = '0;
    logic [INDEX_WIDTH-1:0]       s_user_index  = '0;
    logic [INDEX_WIDTH-1:0]       s_item_index  = '0;
    logic signed [DATA_WIDTH-1:0] s_rating      = '0;
    logic signed [DATA_WIDTH-1:0] s_prior_sum   = '0;
    logic signed [DATA_WIDTH-1:0] s_baseline    = '0;
    logic signed [DATA_WIDTH-1:0] s_write_value = '0;
    logic                         m_valid;
    logic                         m_ready       = 1'b0;
    logic signed [DATA_WIDTH-1:0] m_prediction;
    logic signed [DATA_WIDTH-1:0] m_error;
    logic [SQ_WIDTH-1:0]          m_squared_error;
    logic signed [DATA_WIDTH-1:0] m_new_user_feature;
    logic signed [DATA_WIDTH-1:0] m_new_item_feature;

    int fail_count, pending, results_seen;
    int requests_sent  = 0;
    int idle_cycles    = 0;
    int settings_count = 0;
    bit quiet          = 1'b0;

    // indexes whose table entries hold a written value
    bit user_written[TABLE_DEPTH];
    bit item_written[TABLE_DEPTH];
    int user_pool[$];
    int item_pool[$];

    always #5 aclk = ~aclk;

    factorization_sgd_rating_step i_dut (.*);

    fsgd_step_checker i_checker (.*);

    // watchdog on handshake progress
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("** factorization_sgd_rating_step: FAILED **");
            $finish;
        end
    end

    // result side stalls
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    function automatic logic [DATA_WIDTH-1:0] random_q16();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 1 << 19) - (1 << 18);
            2: return $urandom_range(0, 200 << 16) - (100 << 16);
            3: return $urandom_range(0, 12 << 16);
            default: begin
                case ($urandom_range(0, 4))
                    0: return 32'h7fffffff;
                    1: return 32'h80000000;
                    2: return 32'h0;
                    3: return 32'h1;
                    default: return 32'hffffffff;
                endcase
            end
        endcase
    endfunction

    // one request on the input channel
    task automatic send(cmd_t cmd, int ui, int ii, logic [31:0] rating,
                        logic [31:0] prior, logic [31:0] base_in, logic [31:0] wval);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_command     <= cmd;
        s_user_index  <= INDEX_WIDTH'(ui);
        s_item_index  <= INDEX_WIDTH'(ii);
        s_rating      <= rating;
        s_prior_sum   <= prior;
        s_baseline    <= base_in;
        s_write_value <= wval;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
        if (cmd == CMD_WRITE_USER && !user_written[ui]) begin
            user_written[ui] = 1'b1;
            user_pool = {user_pool, ui};
        end
        if (cmd == CMD_WRITE_ITEM && !item_written[ii]) begin
            item_written[ii] = 1'b1;
            item_pool = {item_pool, ii};
        end
    endtask

    // drain every result, then allow the sequencer to fall idle
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // all six registers, write enable held across the burst
    task automatic load_config(logic [31:0] rate, logic [31:0] regul, logic [31:0] init_f,
                               logic [31:0] remain, logic [31:0] lo, logic [31:0] hi);
        logic [31:0] vals[6];
        vals = '{rate, regul, init_f, remain, lo, hi};
        cfg_wr_en <= 1'b1;
        for (int r = 0; r < 6; r++) begin
            cfg_index <= CFG_INDEX_WIDTH'(r);
            cfg_data  <= vals[r];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        settings_count++;
    endtask

    task automatic random_request();
        int pick, ui, ii;
        cmd_t cmd;
        pick = $urandom_range(0, 99);
        if (pick < 15)      cmd = CMD_WRITE_USER;
        else if (pick < 30) cmd = CMD_WRITE_ITEM;
        else if (pick < 75) cmd = CMD_TRAIN;
        else                cmd = CMD_CACHE;
        if (cmd == CMD_TRAIN || cmd == CMD_CACHE) begin
            ui = user_pool[$urandom_range(0, user_pool.size() - 1)];
            ii = item_pool[$urandom_range(0, item_pool.size() - 1)];
        end else begin
            // writes pick a known entry or a random index with equal chance
            ui = $urandom_range(0, 1) ? user_pool[$urandom_range(0, user_pool.size() - 1)]
                                      : $urandom_range(0, TABLE_DEPTH - 1);
            ii = $urandom_range(0, 1) ? item_pool[$urandom_range(0, item_pool.size() - 1)]
                                      : $urandom_range(0, TABLE_DEPTH - 1);
        end
        send(cmd, ui, ii, random_q16(), random_q16(), random_q16(), random_q16());
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes of entries, every command, prior sign, index range corners
        send(CMD_WRITE_USER, 0, 0, 0, 0, 0, 32'h7fffffff);
        send(CMD_WRITE_ITEM, 0, 0, 0, 0, 0, 32'h7fffffff);
        send(CMD_WRITE_USER, 16383, 16383, 0, 0, 0, 32'h80000000);
        send(CMD_WRITE_ITEM, 16383, 16383, 0, 0, 0, 32'h80000000);
        send(CMD_WRITE_USER, 1, 1, 0, 0, 0, 32'h00010000);
        send(CMD_WRITE_ITEM, 1, 1, 0, 0, 0, 32'h00020000);
        send(CMD_TRAIN, 0, 0, 32'h7fffffff, 32'h00010000, 0, 0);
        send(CMD_TRAIN, 16383, 16383, 32'h80000000, 0, 32'h80000000, 0);
        send(CMD_CACHE, 0, 16383, 0, 32'h7fffffff, 32'h7fffffff, 0);
        send(CMD_CACHE, 1, 1, 0, 32'hffff0000, 32'h00030000, 0);
        send(CMD_TRAIN, 1, 1, 32'h00050000, 32'h00000001, 32'h80000000, 0);
        send(CMD_TRAIN, 16383, 0, 32'hffffffff, 32'h80000000, 32'h7fffffff, 0);
        send(CMD_WRITE_USER, 5, 5, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0);
        send(CMD_CACHE, 5, 1, 0, 0, 32'hfff00000, 32'hffffffff);
        send(CMD_TRAIN, 5, 16383, 32'h00000001, 0, 32'h00008000, 32'h7fffffff);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                settle();
                case (phase)
                    1: load_config(655, 1311, 6554, 40, 32'h00010000, 32'h000a0000);
                    2: load_config(32'h7fffffff, 32'h80000000, 32'h7fffffff, 255,
                                   32'h80000000, 32'h7fffffff);
                    // floor above ceiling
                    3: load_config(32'hffff8000, 0, 32'h80000000, 0,
                                   32'h00050000, 32'h00020000);
                    4: load_config(random_q16(), random_q16(), random_q16(),
                                   $urandom_range(0, 255), random_q16(), random_q16());
                    default: load_config($urandom, $urandom, $urandom, $urandom,
                                         random_q16(), random_q16());
                endcase
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
                random_request();
            end
            quiet = 1'b0;
        end

        settle();
        $display("%0d requests over %0d register settings, %0d results checked",
                 requests_sent, settings_count + 1, results_seen);
        $display("%0d user and %0d item entries written", user_pool.size(), item_pool.size());
        if (fail_count == 0)
            $display("** factorization_sgd_rating_step: PASSED **");
        else
            $display("** factorization_sgd_rating_step: FAILED **");
        $finish;
    end

endmodule
